### hdl/aos_pkg.sv
// Package for the ADC oversampling averager.
// Holds field widths, the reset timeout and the divider status type.
// No dependencies.
package aos_pkg;

   localparam int COUNT_WIDTH = 7;
   localparam int CHAN_WIDTH  = 4;
   localparam int VALUE_WIDTH = 10;
   localparam int SUM_WIDTH   = 16;
   localparam int WAIT_WIDTH  = 8;

   localparam logic [WAIT_WIDTH-1:0] TIMEOUT_RESET = 8'd10;
   localparam logic [WAIT_WIDTH-1:0] WAIT_MAX      = 8'd255;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### hdl/aos_divider.sv
// Iterative restoring divider: 16-bit sum by a 7-bit sample count.
// One quotient bit per cycle; depends on aos_pkg.
module aos_divider
   import aos_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_WIDTH-1:0]   dividend,
   input  logic [COUNT_WIDTH-1:0] divisor,
   output div_status_type         status,
   output logic [SUM_WIDTH-1:0]   quotient
);

   logic [SUM_WIDTH-1:0]         quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]       rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]       dvs_ff, dvs_in;
   logic [$clog2(SUM_WIDTH)-1:0] step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [COUNT_WIDTH:0]         shifted;
   logic [COUNT_WIDTH:0]         trial;
   logic                         fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_WIDTH-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_WIDTH-2:0], fits};
         rem_in  = fits ? trial[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && step_ff == '1)
      else $error("divider did not start a full pass");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == '0 && !start |=> done_ff && !busy_ff)
      else $error("divider did not finish after the last quotient bit");
`endif

endmodule

### hdl/adc_oversample_average_sequencer_unit.sv
// ADC oversampling averager sequencer, top level.
// Decodes each poll word, keeps the sequence state and drives the divider.
// Depends on aos_pkg and aos_divider.
//
// Usage: every poll of the converter is one word on the req_ channel. Each
// accepted poll yields exactly one word on the rsp_ channel carrying the
// converter commands (power up, power down, start, clear done flag) and the
// running sum, or the average on the poll that completes a sequence.
// A poll that does not finish a sequence shows its response in the cycle
// after acceptance. The completing poll runs the serial divider, one
// quotient bit per cycle, and responds once the divider reports done.
// req_ready is low while the divider runs and while a response waits that
// is not being taken, so one poll is in flight at a time.
// When the receiver stalls, the response register holds its word and no new
// poll is accepted. Reset clears the sequence, the sum and the response valid
// flag and loads a timeout limit of 10. csr_write_enable writes the
// timeout limit at once.
module adc_oversample_average_sequencer_unit
   import aos_pkg::*;
#(
   parameter int MAX_SAMPLES = 64,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [WAIT_WIDTH-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COUNT_WIDTH-1:0] req_sample_count,
   input  logic [CHAN_WIDTH-1:0]  req_channel,
   input  logic                   req_conversion_done,
   input  logic [VALUE_WIDTH-1:0] req_conversion_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_finished,
   output logic [SUM_WIDTH-1:0]   rsp_result_value,
   output logic                   rsp_start_conversion,
   output logic [CHAN_WIDTH-1:0]  rsp_start_channel,
   output logic                   rsp_power_up,
   output logic                   rsp_power_down,
   output logic                   rsp_clear_done_flag
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(MAX_SAMPLES);
   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK = (SAMPLE_BITS >= VALUE_WIDTH) ?
      {VALUE_WIDTH{1'b1}} : VALUE_WIDTH'((1 << SAMPLE_BITS) - 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DIVIDE = 1'b1;

   logic                   state_ff, state_in;
   logic [WAIT_WIDTH-1:0]  limit_ff, limit_in;
   logic [COUNT_WIDTH-1:0] index_ff, index_in;
   logic [WAIT_WIDTH-1:0]  wait_ff, wait_in;
   logic                   running_ff, running_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;

   logic                   valid_ff, valid_in;
   logic                   fin_ff, fin_in;
   logic [SUM_WIDTH-1:0]   res_ff, res_in;
   logic                   start_ff, start_in;
   logic [CHAN_WIDTH-1:0]  chan_ff, chan_in;
   logic                   pup_ff, pup_in;
   logic                   pdown_ff, pdown_in;
   logic                   clr_ff, clr_in;

   logic                   accept;
   logic [COUNT_WIDTH-1:0] count;
   logic [SUM_WIDTH-1:0]   sum_add;
   logic [COUNT_WIDTH-1:0] index_inc;
   logic [WAIT_WIDTH-1:0]  wait_inc;
   logic                   div_start;
   div_status_type         div_stat;
   logic [SUM_WIDTH-1:0]   div_quotient;

   aos_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_add),
      .divisor  (count),
      .status   (div_stat),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      count     = (req_sample_count > COUNT_MAX) ? COUNT_MAX : req_sample_count;
      sum_add   = sum_ff + SUM_WIDTH'(req_conversion_value & VALUE_MASK);
      index_inc = index_ff + 1'b1;
      wait_inc  = (wait_ff == WAIT_MAX) ? wait_ff : wait_ff + 1'b1;

      state_in   = state_ff;
      limit_in   = csr_write_enable ? csr_write_data : limit_ff;
      index_in   = index_ff;
      wait_in    = wait_ff;
      running_in = running_ff;
      sum_in     = sum_ff;
      valid_in   = valid_ff && !rsp_ready;
      fin_in     = fin_ff;
      res_in     = res_ff;
      start_in   = start_ff;
      chan_in    = chan_ff;
      pup_in     = pup_ff;
      pdown_in   = pdown_ff;
      clr_in     = clr_ff;
      div_start  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in = 1'b1;
               fin_in   = 1'b0;
               start_in = 1'b0;
               pup_in   = 1'b0;
               pdown_in = 1'b0;
               clr_in   = 1'b0;
               res_in   = sum_ff;
               if (count == '0) begin
                  pdown_in   = 1'b1;
                  index_in   = '0;
                  wait_in    = '0;
                  running_in = 1'b0;
               end else if (index_ff == '0) begin
                  pup_in     = !running_ff;
                  running_in = 1'b1;
                  clr_in     = 1'b1;
                  start_in   = 1'b1;
                  sum_in     = '0;
                  res_in     = '0;
                  wait_in    = '0;
                  index_in   = COUNT_WIDTH'(1);
               end else if (req_conversion_done) begin
                  clr_in  = 1'b1;
                  wait_in = '0;
                  if (index_inc > count) begin
                     index_in   = '0;
                     running_in = 1'b0;
                     fin_in     = 1'b1;
                     valid_in   = 1'b0;
                     div_start  = 1'b1;
                     state_in   = ST_DIVIDE;
                  end else begin
                     index_in = index_inc;
                     start_in = 1'b1;
                     sum_in   = sum_add;
                     res_in   = sum_add;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (wait_inc >= limit_ff) begin
                     index_in = '0;
                  end
               end
               chan_in = start_in ? req_channel : '0;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               sum_in   = div_quotient;
               res_in   = div_quotient;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      fin_ff   <= fin_in;
      res_ff   <= res_in;
      start_ff <= start_in;
      chan_ff  <= chan_in;
      pup_ff   <= pup_in;
      pdown_ff <= pdown_in;
      clr_ff   <= clr_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         limit_ff   <= TIMEOUT_RESET;
         index_ff   <= '0;
         wait_ff    <= TIMEOUT_RESET;
         running_ff <= 1'b0;
         sum_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= limit_in;
         index_ff   <= index_in;
         wait_ff    <= wait_in;
         running_ff <= running_in;
         sum_ff     <= sum_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_finished         = fin_ff;
   assign rsp_result_value     = res_ff;
   assign rsp_start_conversion = start_ff;
   assign rsp_start_channel    = chan_ff;
   assign rsp_power_up         = pup_ff;
   assign rsp_power_down       = pdown_ff;
   assign rsp_clear_done_flag  = clr_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("Divider finished outside the divide state.");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !valid_ff && !req_ready)
      else $error("Response or poll handshake active during divide.");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !start_ff |-> chan_ff == '0)
      else $error("Start channel set without a start request.");
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && fin_ff |-> !pdown_ff && !start_ff && !pup_ff)
      else $error("Finished word carries a converter command.");
`endif

endmodule

### dv/aos_average_checker.sv
// Scoreboard for the ADC oversampling averager: watches the poll, response
// and register ports, predicts each response word and compares it.
// Depends on aos_pkg for the field widths and the reset timeout.
module aos_average_checker
   import aos_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [WAIT_WIDTH-1:0]  csr_write_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [COUNT_WIDTH-1:0] req_sample_count,
   input  logic [CHAN_WIDTH-1:0]  req_channel,
   input  logic                   req_conversion_done,
   input  logic [VALUE_WIDTH-1:0] req_conversion_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_finished,
   input  logic [SUM_WIDTH-1:0]   rsp_result_value,
   input  logic                   rsp_start_conversion,
   input  logic [CHAN_WIDTH-1:0]  rsp_start_channel,
   input  logic                   rsp_power_up,
   input  logic                   rsp_power_down,
   input  logic                   rsp_clear_done_flag,
   output int                     mismatch_count,
   output int                     pending_responses
);

   localparam int SAMPLE_LIMIT = 64;

   typedef struct packed {
      logic                  finished;
      logic [SUM_WIDTH-1:0]  result_value;
      logic                  start_conversion;
      logic [CHAN_WIDTH-1:0] start_channel;
      logic                  power_up;
      logic                  power_down;
      logic                  clear_done_flag;
   } poll_response_type;

   logic [WAIT_WIDTH-1:0]  timeout_limit;
   logic [COUNT_WIDTH-1:0] seq_index;
   logic [WAIT_WIDTH-1:0]  idle_polls;
   logic                   adc_on;
   logic [SUM_WIDTH-1:0]   running_sum;
   poll_response_type      predicted_responses[$];

   initial begin
      mismatch_count    = 0;
      pending_responses = 0;
   end

   task automatic predict_poll_response(input logic [COUNT_WIDTH-1:0] count_in,
                                        input logic [CHAN_WIDTH-1:0] chan,
                                        input logic conv_done,
                                        input logic [VALUE_WIDTH-1:0] conv_value,
                                        output poll_response_type word);
      logic [COUNT_WIDTH-1:0] count;
      word  = '0;
      count = (count_in > SAMPLE_LIMIT) ? COUNT_WIDTH'(SAMPLE_LIMIT) : count_in;
      if (count == 0) begin
         word.power_down = 1'b1;
         seq_index       = '0;
         idle_polls      = '0;
         adc_on          = 1'b0;
      end else if (seq_index == 0) begin
         if (!adc_on) begin
            word.power_up = 1'b1;
            adc_on        = 1'b1;
         end
         word.clear_done_flag  = 1'b1;
         word.start_conversion = 1'b1;
         running_sum           = '0;
         idle_polls            = '0;
         seq_index             = COUNT_WIDTH'(1);
      end else if (conv_done) begin
         word.clear_done_flag = 1'b1;
         idle_polls           = '0;
         running_sum          = running_sum + SUM_WIDTH'(conv_value);
         seq_index            = seq_index + 1'b1;
         if (seq_index > count) begin
            running_sum   = running_sum / SUM_WIDTH'(count);
            seq_index     = '0;
            adc_on        = 1'b0;
            word.finished = 1'b1;
         end else begin
            word.start_conversion = 1'b1;
         end
      end else begin
         if (idle_polls != WAIT_MAX) idle_polls = idle_polls + 1'b1;
         if (idle_polls >= timeout_limit) seq_index = '0;
      end
      word.result_value  = running_sum;
      word.start_channel = word.start_conversion ? chan : '0;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      poll_response_type word;
      if (reset) begin
         timeout_limit = TIMEOUT_RESET;
         seq_index     = '0;
         idle_polls    = TIMEOUT_RESET;
         adc_on        = 1'b0;
         running_sum   = '0;
         predicted_responses.delete();
      end else begin
         if (csr_write_enable) timeout_limit = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               $error("response word arrived with no poll outstanding");
               mismatch_count++;
            end else begin
               word = predicted_responses.pop_front();
               compare_field("finished", word.finished, rsp_finished);
               compare_field("result_value", word.result_value, rsp_result_value);
               compare_field("start_conversion", word.start_conversion,
                             rsp_start_conversion);
               compare_field("start_channel", word.start_channel, rsp_start_channel);
               compare_field("power_up", word.power_up, rsp_power_up);
               compare_field("power_down", word.power_down, rsp_power_down);
               compare_field("clear_done_flag", word.clear_done_flag,
                             rsp_clear_done_flag);
            end
         end
         if (req_valid && req_ready) begin
            predict_poll_response(req_sample_count, req_channel, req_conversion_done,
                                  req_conversion_value, word);
            predicted_responses.push_back(word);
         end
      end
      pending_responses = predicted_responses.size();
   end

endmodule

### dv/tb_adc_oversample_average_sequencer_unit.sv
// Testbench top for the ADC oversampling averager: drives polls, register
// writes and response back-pressure, and reports the verdict.
// Depends on aos_pkg, the averager RTL and aos_average_checker.
module tb_adc_oversample_average_sequencer_unit;
   import aos_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 180;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [WAIT_WIDTH-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COUNT_WIDTH-1:0] req_sample_count = '0;
   logic [CHAN_WIDTH-1:0]  req_channel = '0;
   logic                   req_conversion_done = 1'b0;
   logic [VALUE_WIDTH-1:0] req_conversion_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_finished;
   logic [SUM_WIDTH-1:0]   rsp_result_value;
   logic                   rsp_start_conversion;
   logic [CHAN_WIDTH-1:0]  rsp_start_channel;
   logic                   rsp_power_up;
   logic                   rsp_power_down;
   logic                   rsp_clear_done_flag;

   int mismatch_count;
   int pending_responses;
   int cycle_count = 0;
   int polls_sent = 0;
   int burst_left = 0;
   int cur_limit = TIMEOUT_RESET;
   bit steady = 1'b0;
   bit long_stall_req = 1'b0;

   always #5 clock = ~clock;

   adc_oversample_average_sequencer_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample_count     (req_sample_count),
      .req_channel          (req_channel),
      .req_conversion_done  (req_conversion_done),
      .req_conversion_value (req_conversion_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_finished         (rsp_finished),
      .rsp_result_value     (rsp_result_value),
      .rsp_start_conversion (rsp_start_conversion),
      .rsp_start_channel    (rsp_start_channel),
      .rsp_power_up         (rsp_power_up),
      .rsp_power_down       (rsp_power_down),
      .rsp_clear_done_flag  (rsp_clear_done_flag)
   );

   aos_average_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample_count     (req_sample_count),
      .req_channel          (req_channel),
      .req_conversion_done  (req_conversion_done),
      .req_conversion_value (req_conversion_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_finished         (rsp_finished),
      .rsp_result_value     (rsp_result_value),
      .rsp_start_conversion (rsp_start_conversion),
      .rsp_start_channel    (rsp_start_channel),
      .rsp_power_up         (rsp_power_up),
      .rsp_power_down       (rsp_power_down),
      .rsp_clear_done_flag  (rsp_clear_done_flag),
      .mismatch_count       (mismatch_count),
      .pending_responses    (pending_responses)
   );

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic stop_offering();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic offer_poll(input int count, input int chan, input bit conv_done,
                             input int conv_value);
      if (!steady) begin
         if (burst_left == 0) begin
            idle_gap($urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_sample_count     <= count[COUNT_WIDTH-1:0];
      req_channel          <= chan[CHAN_WIDTH-1:0];
      req_conversion_done  <= conv_done;
      req_conversion_value <= conv_value[VALUE_WIDTH-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      polls_sent++;
   endtask

   task automatic write_limit(input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[WAIT_WIDTH-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_limit = value;
   endtask

   task automatic run_averaging_sequence();
      int count;
      int samples_left;
      int roll;
      int run;
      roll = $urandom_range(0, 99);
      if (roll < 60) count = $urandom_range(1, 8);
      else if (roll < 85) count = $urandom_range(9, 32);
      else if (roll < 95) count = $urandom_range(33, 64);
      else count = $urandom_range(65, 127);
      offer_poll(count, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1023));
      samples_left = (count > 64) ? 64 : count;
      while (samples_left > 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            offer_poll(0, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 1023));
            return;
         end else if (roll < 5) begin
            count = $urandom_range(1, 64);
            offer_poll(count, $urandom_range(0, 15), 1'b1, $urandom_range(0, 1023));
            samples_left--;
         end else if (roll < 15) begin
            if (cur_limit <= 16 && $urandom_range(0, 3) == 0) run = cur_limit + 1;
            else run = $urandom_range(1, 3);
            repeat (run) offer_poll(count, $urandom_range(0, 15), 1'b0,
                                    $urandom_range(0, 1023));
         end else begin
            offer_poll(count, $urandom_range(0, 15), 1'b1, $urandom_range(0, 1023));
            samples_left--;
         end
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("adc_oversample_average_sequencer_unit: mismatch");
      $finish;
   end

   initial begin
      int       mode_left;
      int       mode;
      bit [7:0] pattern;
      mode_left = 0;
      mode      = 0;
      pattern   = 8'hFF;
      forever begin
         @(negedge clock);
         if (long_stall_req) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            long_stall_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(64, 256);
               pattern   = 8'($urandom) | 8'h01;
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: begin
                  pattern = {pattern[6:0], pattern[7]};
                  rsp_ready <= pattern[0];
               end
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int limits[PHASE_COUNT];
      int target;
      bit mid_done;
      limits = '{1, 255, 0, 10, 2, 3, 10, 1};
      limits[3] = $urandom_range(4, 254);
      limits[6] = $urandom_range(1, 255);
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Power down, single-sample average, two samples at the value extremes.
      offer_poll(0, 0, 1'b0, 0);
      offer_poll(1, 15, 1'b1, 1023);
      offer_poll(1, 15, 1'b1, 1023);
      offer_poll(2, 0, 1'b0, 0);
      offer_poll(2, 5, 1'b1, 0);
      offer_poll(2, 5, 1'b1, 1023);
      // Oversized count, then a power down in the middle of the sequence.
      offer_poll(127, 10, 1'b0, 0);
      offer_poll(127, 10, 1'b1, 512);
      offer_poll(0, 3, 1'b1, 1023);
      // Ten polls without a finished conversion restart the sequence.
      offer_poll(3, 1, 1'b0, 0);
      repeat (10) offer_poll(3, 1, 1'b0, $urandom_range(0, 1023));
      offer_poll(3, 2, 1'b1, 100);
      offer_poll(3, 2, 1'b1, 200);
      offer_poll(3, 2, 1'b1, 300);
      // The count drops below the sample index, so the sequence ends early.
      offer_poll(1, 2, 1'b1, 400);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         stop_offering();
         wait (pending_responses == 0);
         repeat (25) @(negedge clock);
         write_limit(limits[p]);
         steady   = (p == 2);
         target   = polls_sent + PHASE_ITEMS;
         mid_done = 1'b0;
         while (polls_sent < target) begin
            if (!mid_done && polls_sent >= target - PHASE_ITEMS / 2) begin
               mid_done = 1'b1;
               if (p == 3) long_stall_req = 1'b1;
               if (p == 5) begin
                  stop_offering();
                  wait (pending_responses == 0);
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               offer_poll($urandom_range(0, 127), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)), $urandom_range(0, 1023));
            end else begin
               run_averaging_sequence();
            end
         end
      end

      stop_offering();
      wait (pending_responses == 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("adc_oversample_average_sequencer_unit: match");
      end else begin
         $display("adc_oversample_average_sequencer_unit: mismatch");
      end
      $finish;
   end

endmodule
